// File: design/fdt_pkg.sv
// Shared constants, types and codes for the float to decimal text converter.
package fdt_pkg;

	// Format and limits.
	localparam int MAX_FRAC_DIGITS = 7;
	localparam int RESULT_CAP      = 19;
	localparam int INT_DIGITS      = 10;
	localparam int MANT_W          = 24;
	localparam int EXP_BIAS        = 127;
	localparam int EXP_TOO_LARGE   = 31;
	localparam int EXP_TOO_SMALL   = -23;
	localparam int EXP_LARGE_B     = EXP_BIAS + EXP_TOO_LARGE;
	localparam int EXP_SMALL_B     = EXP_BIAS + EXP_TOO_SMALL;
	localparam int BUF_W           = 7;
	localparam int BUF_RESET       = 32;

	// Counter widths.
	localparam int FRAC_W = $clog2(MAX_FRAC_DIGITS + 1);
	localparam int FI_W   = $clog2(MAX_FRAC_DIGITS);
	localparam int POS_W  = $clog2(RESULT_CAP + 1);
	localparam int IDIG_W = $clog2(INT_DIGITS + 1);
	localparam int IDX_W  = $clog2(INT_DIGITS);
	localparam int CNT_W  = 5;

	// Result status codes.
	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_TOO_LARGE = 2'd1;
	localparam logic [1:0] STATUS_TOO_SMALL = 2'd2;

	// ASCII characters.
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_MINUS = 8'h2D;

	typedef logic [INT_DIGITS-1:0][3:0] bcd_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_DABBLE,
		OP_SHR,
		OP_MUL10
	} unit_op_t;

	typedef struct packed {
		bcd_t              bcd;
		logic [MANT_W-1:0] mant;
		logic [3:0]        digit;
	} unit_res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_INT,
		ST_SHR,
		ST_PREP,
		ST_DIGITS,
		ST_EMIT,
		ST_ERR
	} state_t;

endpackage

// File: design/fdt_step_unit.sv
// Shared step unit: binary to BCD step, alignment shift and multiply by ten.
module fdt_step_unit import fdt_pkg::*; (
	input  unit_op_t          op,
	input  bcd_t              bcd_in,
	input  logic [MANT_W-1:0] mant_in,
	output unit_res_t         res
);

	bcd_t                  adj;
	logic [4*INT_DIGITS:0] shifted;
	logic [MANT_W+3:0]     prod;

	always_comb begin
		// Add three to every BCD digit of five or more before the shift.
		for (int i = 0; i < INT_DIGITS; i++) begin
			adj[i] = (bcd_in[i] >= 4'd5) ? bcd_in[i] + 4'd3 : bcd_in[i];
		end
		shifted = {adj, mant_in[MANT_W-1]};

		// Ten times the fraction as eight times plus two times.
		prod = {1'b0, mant_in, 3'b000} + {3'b000, mant_in, 1'b0};

		res = '{bcd: bcd_in, mant: mant_in, digit: 4'd0};
		case (op)
			OP_DABBLE: begin
				res.bcd  = shifted[4*INT_DIGITS-1:0];
				res.mant = {mant_in[MANT_W-2:0], 1'b0};
			end
			OP_SHR: begin
				res.mant = {1'b0, mant_in[MANT_W-1:1]};
			end
			OP_MUL10: begin
				res.mant  = prod[MANT_W-1:0];
				res.digit = prod[MANT_W+3:MANT_W];
			end
			default: begin
				res = '{bcd: bcd_in, mant: mant_in, digit: 4'd0};
			end
		endcase
	end

endmodule

// File: design/float_to_decimal_text.sv
// Top level: converts a single-precision bit pattern into a stream of ASCII characters.
// Steps: capture and decode, then binary to BCD steps for a non-negative exponent or
// alignment shifts for a negative one, a setup state, the fraction digit steps on the
// shared step unit, then one character per cycle while the output is not stalled.
// A new value is taken only in the idle state, and in_ready rises once the
// last character is in the output register. Reset clears control state, buffer_size is 32.
module float_to_decimal_text import fdt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [31:0]      float_bits,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [BUF_W-1:0] cfg_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       out_char,
	output logic             char_valid,
	output logic [1:0]       status,
	output logic             last
);

	state_t            state_q, state_d;
	logic [31:0]       bits_q;
	logic              sign_q;
	logic [1:0]        err_status_q;
	logic [MANT_W-1:0] mant_q;
	bcd_t              bcd_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [IDIG_W-1:0] idig_q;
	logic [FRAC_W-1:0] budget_q;
	logic              frac_zero_q;
	logic [FRAC_W-1:0] dig_q;
	logic [FRAC_W-1:0] last_nz_q;
	logic [3:0]        frac_dig_q [MAX_FRAC_DIGITS];
	logic [POS_W-1:0]  pos_q;
	logic [BUF_W-1:0]  buffer_size_q;
	logic              out_valid_q;
	logic [7:0]        out_char_q;
	logic              char_valid_q;
	logic [1:0]        status_q;
	logic              last_q;

	unit_op_t          unit_op;
	unit_res_t         unit_res;

	logic [7:0]        exp_b;
	logic              is_zero, too_large, too_small, pos_exp;
	logic [7:0]        exp_diff;
	logic [CNT_W-1:0]  cnt_init;
	logic [IDIG_W-1:0] idig_d;
	logic [POS_W-1:0]  npre;
	logic signed [8:0] bud_raw, bud_cap;
	logic [FRAC_W-1:0] budget_d;
	logic              out_free;
	logic [FRAC_W-1:0] flen;
	logic [POS_W-1:0]  n_total, rel, fi_wide;
	logic [IDX_W-1:0]  int_idx;
	logic [7:0]        emit_char;
	logic              emit_last;

	// Configuration register.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_size_q <= BUF_W'(BUF_RESET);
		end else if (cfg_valid && cfg_ready) begin
			buffer_size_q <= cfg_data;
		end
	end

	// Shared step unit.
	fdt_step_unit u_step (
		.op      (unit_op),
		.bcd_in  (bcd_q),
		.mant_in (mant_q),
		.res     (unit_res)
	);

	// Exponent decode of the captured request.
	always_comb begin
		exp_b     = bits_q[30:23];
		is_zero   = (bits_q[30:0] == 31'd0);
		too_large = !is_zero && (exp_b >= 8'(EXP_LARGE_B));
		too_small = !is_zero && (exp_b < 8'(EXP_SMALL_B));
		pos_exp   = (exp_b >= 8'(EXP_BIAS));
		exp_diff  = pos_exp ? exp_b - 8'(EXP_BIAS - 1) : 8'(EXP_BIAS - 1) - exp_b;
		cnt_init  = exp_diff[CNT_W-1:0];
	end

	// Integer digit count and fraction digit budget.
	always_comb begin
		idig_d = IDIG_W'(1);
		for (int i = 0; i < INT_DIGITS; i++) begin
			if (bcd_q[i] != 4'd0) begin
				idig_d = IDIG_W'(i + 1);
			end
		end
		npre    = POS_W'(sign_q) + POS_W'(idig_d) + POS_W'(1);
		bud_raw = $signed({2'b00, buffer_size_q}) - $signed(9'(npre)) - 9'sd1;
		bud_cap = $signed(9'(RESULT_CAP)) - $signed(9'(npre));
		if (bud_raw <= 9'sd0) begin
			budget_d = '0;
		end else if (bud_raw > $signed(9'(MAX_FRAC_DIGITS))) begin
			budget_d = FRAC_W'(MAX_FRAC_DIGITS);
		end else begin
			budget_d = bud_raw[FRAC_W-1:0];
		end
		if ($signed(9'(budget_d)) > bud_cap) begin
			budget_d = bud_cap[FRAC_W-1:0];
		end
	end

	// Character selection while the text is sent out.
	always_comb begin
		if (frac_zero_q) begin
			flen = FRAC_W'(1);
		end else if (budget_q == '0) begin
			flen = '0;
		end else if (last_nz_q == '0) begin
			flen = FRAC_W'(1);
		end else begin
			flen = last_nz_q;
		end
		n_total   = POS_W'(sign_q) + POS_W'(idig_q) + POS_W'(1) + POS_W'(flen);
		rel       = pos_q - POS_W'(sign_q);
		int_idx   = IDX_W'(idig_q - IDIG_W'(1) - rel[IDIG_W-1:0]);
		fi_wide   = rel - POS_W'(idig_q) - POS_W'(1);
		emit_last = (pos_q == n_total - POS_W'(1));
		if (sign_q && (pos_q == '0)) begin
			emit_char = CH_MINUS;
		end else if (rel < POS_W'(idig_q)) begin
			emit_char = CH_ZERO | {4'd0, bcd_q[int_idx]};
		end else if (rel == POS_W'(idig_q)) begin
			emit_char = CH_DOT;
		end else if (frac_zero_q) begin
			emit_char = CH_ZERO;
		end else begin
			emit_char = CH_ZERO | {4'd0, frac_dig_q[fi_wide[FI_W-1:0]]};
		end
	end

	assign out_free = !out_valid_q || out_ready;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (too_large || too_small) begin
					state_d = ST_ERR;
				end else if (is_zero) begin
					state_d = ST_PREP;
				end else if (pos_exp) begin
					state_d = ST_INT;
				end else if (cnt_init == '0) begin
					state_d = ST_PREP;
				end else begin
					state_d = ST_SHR;
				end
			end
			ST_INT, ST_SHR: begin
				if (cnt_q == CNT_W'(1)) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				if ((mant_q == '0) || (budget_d == '0)) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_DIGITS;
				end
			end
			ST_DIGITS: begin
				if (dig_q + FRAC_W'(1) == budget_q) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free && emit_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_ERR: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		in_ready = (state_q == ST_IDLE);
		case (state_q)
			ST_INT:    unit_op = OP_DABBLE;
			ST_SHR:    unit_op = OP_SHR;
			ST_DIGITS: unit_op = OP_MUL10;
			default:   unit_op = OP_HOLD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					bits_q <= float_bits;
				end
			end
			ST_DECODE: begin
				mant_q       <= is_zero ? '0 : {1'b1, bits_q[22:0]};
				sign_q       <= bits_q[31] && !is_zero;
				bcd_q        <= '0;
				cnt_q        <= cnt_init;
				err_status_q <= too_large ? STATUS_TOO_LARGE : STATUS_TOO_SMALL;
			end
			ST_INT, ST_SHR: begin
				mant_q <= unit_res.mant;
				bcd_q  <= unit_res.bcd;
				cnt_q  <= cnt_q - CNT_W'(1);
			end
			ST_PREP: begin
				idig_q      <= idig_d;
				budget_q    <= budget_d;
				frac_zero_q <= (mant_q == '0);
				dig_q       <= '0;
				last_nz_q   <= '0;
				pos_q       <= '0;
			end
			ST_DIGITS: begin
				mant_q                     <= unit_res.mant;
				frac_dig_q[dig_q[FI_W-1:0]] <= unit_res.digit;
				if (unit_res.digit != 4'd0) begin
					last_nz_q <= dig_q + FRAC_W'(1);
				end
				dig_q <= dig_q + FRAC_W'(1);
			end
			ST_EMIT: begin
				if (out_free) begin
					pos_q <= pos_q + POS_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// Output register: holds one result until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free && ((state_q == ST_EMIT) || (state_q == ST_ERR))) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && (state_q == ST_EMIT)) begin
			out_char_q   <= emit_char;
			char_valid_q <= 1'b1;
			status_q     <= STATUS_OK;
			last_q       <= emit_last;
		end else if (out_free && (state_q == ST_ERR)) begin
			out_char_q   <= 8'd0;
			char_valid_q <= 1'b0;
			status_q     <= err_status_q;
			last_q       <= 1'b1;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_char   = out_char_q;
	assign char_valid = char_valid_q;
	assign status     = status_q;
	assign last       = last_q;

	// An error result is always the only and final result of its conversion.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !char_valid |-> last && (status != STATUS_OK))
		else $error("error result without last flag or error status");

	// A character result always carries the ok status.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && char_valid |-> (status == STATUS_OK))
		else $error("character result with an error status");

	// Once a request is taken the block is busy on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready while a conversion is under way");

	// Fraction digits never exceed the budget set up for them.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIGITS) |-> (dig_q < budget_q))
		else $error("fraction digit counter past its budget");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the float to decimal text converter, one character per check.
module tb_top import fdt_pkg::*; ();

	// Cycles with no handshake on any port before the run is called stuck.
	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 80;
	localparam int SIZE_STEP_VALUES = 8;
	localparam int MIXED_VALUES = 84;

	typedef struct packed {
		logic [7:0] ch;
		logic       cv;
		logic [1:0] st;
		logic       lst;
	} text_char_t;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	logic [31:0]      float_bits;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [BUF_W-1:0] cfg_data;
	logic             out_valid;
	logic             out_ready;
	logic [7:0]       out_char;
	logic             char_valid;
	logic [1:0]       status;
	logic             last;

	text_char_t       expected_chars[$];
	logic [BUF_W-1:0] buf_size;
	bit               calm;
	int               err_count;
	int               values_sent;
	int               chars_checked;
	int               sizes_written;

	float_to_decimal_text uut (.*);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Builds the expected character stream for one value at the current buffer size.
	function automatic void predict_text(input logic [31:0] bits);
		logic [7:0]  txt[$];
		logic [7:0]  dig[$];
		logic [31:0] mant;
		logic [31:0] ipart;
		logic [31:0] fpart;
		int          exp2;
		int          budget;
		text_char_t  c;
		ipart = 32'd0;
		fpart = 32'd0;
		if (bits[30:0] == 31'd0) begin
			txt.push_back(CH_ZERO);
			txt.push_back(CH_DOT);
			txt.push_back(CH_ZERO);
		end else begin
			exp2 = int'(bits[30:23]) - EXP_BIAS;
			if (exp2 >= EXP_TOO_LARGE) begin
				c = '{8'h00, 1'b0, STATUS_TOO_LARGE, 1'b1};
				expected_chars.push_back(c);
				return;
			end
			if (exp2 < EXP_TOO_SMALL) begin
				c = '{8'h00, 1'b0, STATUS_TOO_SMALL, 1'b1};
				expected_chars.push_back(c);
				return;
			end
			mant = {8'h00, 1'b1, bits[22:0]};
			// Split into integer part and a 24-bit binary fraction.
			if (exp2 >= 23) begin
				ipart = mant << (exp2 - 23);
			end else if (exp2 >= 0) begin
				ipart = mant >> (23 - exp2);
				fpart = (mant << (exp2 + 1)) & 32'h00FF_FFFF;
			end else begin
				fpart = mant >> (-(exp2 + 1));
			end
			if (bits[31])
				txt.push_back(CH_MINUS);
			if (ipart == 32'd0) begin
				txt.push_back(CH_ZERO);
			end else begin
				while (ipart != 32'd0) begin
					dig.push_front(CH_ZERO + 8'(ipart % 10));
					ipart = ipart / 10;
				end
				foreach (dig[i])
					txt.push_back(dig[i]);
			end
			txt.push_back(CH_DOT);
			// Truncated fraction digits, limited by the buffer and the digit caps, then trailing zeros trimmed.
			if (fpart == 32'd0) begin
				txt.push_back(CH_ZERO);
			end else begin
				budget = int'(buf_size) - txt.size() - 1;
				if (budget > MAX_FRAC_DIGITS)
					budget = MAX_FRAC_DIGITS;
				if (budget > RESULT_CAP - txt.size())
					budget = RESULT_CAP - txt.size();
				for (int m = 0; m < budget; m++) begin
					fpart = fpart * 10;
					txt.push_back(CH_ZERO + 8'(fpart >> 24));
					fpart = fpart & 32'h00FF_FFFF;
				end
				while (txt.size() >= 2 && txt[txt.size() - 1] == CH_ZERO
						&& txt[txt.size() - 2] != CH_DOT)
					void'(txt.pop_back());
			end
		end
		foreach (txt[k]) begin
			c = '{txt[k], 1'b1, STATUS_OK, (k == txt.size() - 1)};
			expected_chars.push_back(c);
		end
	endfunction

	// Random value: mostly convertible exponents, some boundaries, zeros and raw noise.
	function automatic logic [31:0] random_float();
		logic [7:0]  e;
		logic [22:0] m;
		logic        s;
		int          pick;
		s = 1'($urandom_range(1));
		m = 23'($urandom);
		if ($urandom_range(2) == 0) begin
			pick = int'($urandom_range(23));
			m = (m >> pick) << pick;
		end
		pick = int'($urandom_range(99));
		if (pick < 70) begin
			e = 8'($urandom_range(EXP_LARGE_B - 1, EXP_SMALL_B));
		end else if (pick < 80) begin
			e = 8'($urandom_range(255));
		end else if (pick < 90) begin
			case ($urandom_range(5))
				0: e = 8'd0;
				1: e = 8'(EXP_SMALL_B - 1);
				2: e = 8'(EXP_SMALL_B);
				3: e = 8'(EXP_LARGE_B - 1);
				4: e = 8'(EXP_LARGE_B);
				default: e = 8'hFF;
			endcase
		end else if (pick < 95) begin
			return {s, 31'd0};
		end else begin
			return $urandom;
		end
		return {s, e, m};
	endfunction

	// Output side ready, stalling at random unless in a calm stretch.
	always @(negedge clk)
		out_ready <= calm || ($urandom_range(99) >= 12);

	// Compares each accepted character with the oldest expected one.
	always @(posedge clk) begin
		text_char_t got;
		text_char_t want;
		if (arst_n && out_valid && out_ready) begin
			got = '{out_char, char_valid, status, last};
			if (expected_chars.size() == 0) begin
				$display("%0t: unexpected character %h valid %b status %0d last %b",
					$time, out_char, char_valid, status, last);
				err_count++;
			end else begin
				want = expected_chars.pop_front();
				if (got != want) begin
					$display("%0t: char/valid/status/last expected %h/%b/%0d/%b got %h/%b/%0d/%b",
						$time, want.ch, want.cv, want.st, want.lst,
						got.ch, got.cv, got.st, got.lst);
					err_count++;
				end
				chars_checked++;
			end
		end
	end

	// Ends the run when no request moves for too long.
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("timeout after %0d cycles without progress", STALL_LIMIT);
		$display("float_to_decimal_text: mismatch");
		$finish;
	end

	// Sends one value request; called and returning just after a falling edge.
	task automatic send_value(input logic [31:0] bits);
		while (!calm && $urandom_range(99) < 12) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		float_bits <= bits;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_text(bits);
		values_sent++;
		@(negedge clk);
	endtask

	// Writes the buffer size register while the converter is idle.
	task automatic write_buffer_size(input logic [BUF_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		buf_size = value;
		sizes_written++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Stops sending and waits until every expected character has arrived.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_chars.size() != 0)
			@(negedge clk);
	endtask

	// Both zeros and simple signed values.
	task automatic test_zero_and_sign();
		send_value(32'h0000_0000);
		send_value(32'h8000_0000);
		send_value(32'h3F80_0000);
		send_value(32'hBF80_0000);
		send_value(32'hBF00_0000);
		wait_idle();
	endtask

	// Infinity, NaN and both ends of the convertible exponent range.
	task automatic test_range_limits();
		send_value(32'h7F80_0000);
		send_value(32'hFF80_0000);
		send_value(32'h7FC0_0001);
		send_value(32'h4F00_0000);
		send_value(32'hCEFF_FFFF);
		send_value(32'h3400_0000);
		send_value(32'hB380_0000);
		send_value(32'h0000_0001);
		send_value(32'h807F_FFFF);
		wait_idle();
	endtask

	// Fraction digits: truncation, trailing zero trimming and whole numbers.
	task automatic test_fraction_digits();
		send_value(32'h3DCC_CCCD);
		send_value(32'h4049_0FDB);
		send_value(32'hC2F6_E979);
		send_value(32'h4B18_9680);
		send_value(32'h3F40_0000);
		send_value(32'h3FFF_FFFF);
		send_value(32'h3F80_0001);
		wait_idle();
	endtask

	// A small buffer leaves one fraction digit or none after the dot; a large one hits the digit cap.
	task automatic test_digit_budget();
		write_buffer_size(7'd4);
		send_value(32'hC2F6_E979);
		send_value(32'h3DCC_CCCD);
		wait_idle();
		write_buffer_size(7'd64);
		send_value(32'h3DCC_CCCD);
		wait_idle();
	endtask

	// Random values under a sweep of buffer sizes, both register extremes included.
	task automatic test_random_sizes();
		logic [BUF_W-1:0] sizes[9];
		sizes = '{7'd1, 7'd2, 7'd5, 7'd9, 7'd12, 7'd64, 7'd127, 7'd0, 7'd0};
		sizes[8] = 7'($urandom_range(127));
		foreach (sizes[j]) begin
			write_buffer_size(sizes[j]);
			for (int i = 0; i < SIZE_STEP_VALUES; i++)
				send_value(random_float());
			wait_idle();
		end
	endtask

	// Long random run at the reset size, with a stretch free of stalls.
	task automatic test_random_values();
		write_buffer_size(BUF_W'(BUF_RESET));
		for (int i = 0; i < MIXED_VALUES; i++) begin
			calm = (i >= 40 && i < 80);
			send_value(random_float());
		end
		calm = 1'b0;
		wait_idle();
	endtask

	// Reset, the tests in turn, then the verdict.
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		float_bits = 32'd0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		out_ready = 1'b0;
		calm = 1'b0;
		buf_size = BUF_W'(BUF_RESET);
		err_count = 0;
		values_sent = 0;
		chars_checked = 0;
		sizes_written = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_zero_and_sign();
		test_range_limits();
		test_fraction_digits();
		test_digit_budget();
		test_random_sizes();
		test_random_values();

		wait_idle();
		repeat (TAIL_CYCLES) @(negedge clk);
		$display("Converted %0d values into %0d checked characters over %0d buffer size writes,",
			values_sent, chars_checked, sizes_written);
		$display("covering zeros, out-of-range exponents, fraction trimming and digit budgets.");
		if (err_count == 0) begin
			$display("float_to_decimal_text: match");
		end else begin
			$display("float_to_decimal_text: mismatch");
		end
		$finish;
	end

endmodule

// File: sim.f
design/fdt_pkg.sv
design/fdt_step_unit.sv
design/float_to_decimal_text.sv
tb/tb_top.sv
